>>> sv/packrat_memo_table_top_defines.svh
// ----------------------------------------------------------------------------
// packrat memo table assertion macros
// shared property wrappers for the memo table checks
// ----------------------------------------------------------------------------
`ifndef PACKRAT_MEMO_TABLE_TOP_DEFINES_SVH
`define PACKRAT_MEMO_TABLE_TOP_DEFINES_SVH

// same-cycle implication, reset aware
`define PMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("memo table check failed");

// next-cycle implication, reset aware
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("memo table check failed");

`endif

>>> sv/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// types and constants shared by the memo table controller and datapath
// ----------------------------------------------------------------------------
package pmt_pkg;

	localparam int KEY_W     = 48;
	localparam int SLOTS_W   = 13;
	localparam int DIV_CNT_W = 6;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 13'd4096;

	// request codes
	localparam logic [1:0] REQ_LOOKUP   = 2'd0;
	localparam logic [1:0] REQ_REC_SUCC = 2'd1;
	localparam logic [1:0] REQ_REC_FAIL = 2'd2;

	// result codes
	localparam logic [1:0] CODE_NONE = 2'd0;
	localparam logic [1:0] CODE_SUCC = 2'd1;
	localparam logic [1:0] CODE_FAIL = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] position;
		logic [15:0] memo_point;
		logic [31:0] state_tag;
		logic [31:0] tree_handle;
		logic [31:0] consumed_in;
	} pmt_req_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [31:0] new_position;
		logic [31:0] tree_out;
	} pmt_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [31:0]      state_tag;
		logic [31:0]      tree;
		logic [31:0]      consumed;
		logic [1:0]       result;
	} pmt_entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic load;
		logic div_step;
		logic rd_en;
		logic resp;
	} pmt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic div_last;
	} pmt_sts_t;

endpackage

>>> sv/pmt_ram.sv
// ----------------------------------------------------------------------------
// pmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/pmt_ctrl.sv
// ----------------------------------------------------------------------------
// pmt_ctrl
// sequencer: clearing pass, remainder loop, slot read, response and update
// ----------------------------------------------------------------------------
module pmt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pmt_pkg::pmt_sts_t sts,
	output pmt_pkg::pmt_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_DIV;
			ST_DIV:   if (sts.div_last) state_d = ST_READ;
			ST_READ:  state_d = ST_RESP;
			ST_RESP:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.div_step = (state_q == ST_DIV);
		cmd.rd_en    = (state_q == ST_READ);
		cmd.resp     = (state_q == ST_RESP);
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_RESP);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

>>> sv/pmt_dp.sv
// ----------------------------------------------------------------------------
// pmt_dp
// slot count register, key remainder loop, slot memory and response logic
// ----------------------------------------------------------------------------
module pmt_dp #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmt_pkg::pmt_cmd_t                 cmd,
	output pmt_pkg::pmt_sts_t                 sts,
	input  pmt_pkg::pmt_req_t                 req,
	input  logic                              cfg_we,
	input  logic [pmt_pkg::SLOTS_W-1:0]       cfg_wdata,
	output pmt_pkg::pmt_rsp_t                 rsp
);

	localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW        = pmt_pkg::SLOTS_W;
	localparam int KW        = pmt_pkg::KEY_W;
	localparam int CW        = pmt_pkg::DIV_CNT_W;
	localparam int CLAMP     = (TABLE_DEPTH > (2 ** SW) - 1) ? (2 ** SW) - 1 : TABLE_DEPTH;
	localparam int ENTRY_W   = $bits(pmt_pkg::pmt_entry_t);

	logic [SW-1:0]     slots_q;
	logic [SW-1:0]     eff_slots;
	pmt_pkg::pmt_req_t req_q;
	logic [KW-1:0]     key;
	logic [KW-1:0]     key_sh_q;
	logic [SW-1:0]     div_q;
	logic [SW-1:0]     rem_q;
	logic [SW:0]       trial;
	logic [CW-1:0]     div_cnt_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  idx;
	pmt_pkg::pmt_entry_t rd_entry;
	pmt_pkg::pmt_entry_t wr_entry;
	logic [ENTRY_W-1:0]  rdata;
	logic              is_record;
	logic              hit;
	logic [32:0]       sum;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	pmt_pkg::pmt_rsp_t rsp_d;
	pmt_pkg::pmt_rsp_t rsp_q;

	// slot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= pmt_pkg::SLOTS_RESET;
		end else if (cfg_we) begin
			slots_q <= cfg_wdata;
		end
	end

	// zero counts as one, clamp to the table depth
	always_comb begin
		eff_slots = slots_q;
		if (slots_q == '0) eff_slots = SW'(1);
		if (slots_q > SW'(CLAMP)) eff_slots = SW'(CLAMP);
	end

	assign key = {req_q.position, req_q.memo_point};

	// remainder loop, one key bit per step
	assign trial = {rem_q, key_sh_q[KW-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req;
			key_sh_q  <= {req.position, req.memo_point};
			div_q     <= eff_slots;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			key_sh_q  <= key_sh_q << 1;
			div_cnt_q <= div_cnt_q + CW'(1);
			if (trial >= {1'b0, div_q}) begin
				rem_q <= SW'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[SW-1:0];
			end
		end
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	assign sts.clr_last = (clr_cnt_q == IDX_W'(TABLE_DEPTH - 1));
	assign sts.div_last = (div_cnt_q == CW'(KW - 1));

	assign idx = IDX_W'(rem_q);

	// slot memory
	assign ram_we    = cmd.clr_step || (cmd.resp && is_record);
	assign ram_waddr = cmd.clr_step ? clr_cnt_q : idx;
	assign ram_wdata = cmd.clr_step ? '0 : wr_entry;

	pmt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(idx),
		.rdata(rdata)
	);

	assign rd_entry = rdata;

	// record entry
	assign is_record = (req_q.req_type == pmt_pkg::REQ_REC_SUCC) ||
		(req_q.req_type == pmt_pkg::REQ_REC_FAIL);

	always_comb begin
		wr_entry.valid     = 1'b1;
		wr_entry.key       = key;
		wr_entry.state_tag = req_q.state_tag;
		wr_entry.tree      = req_q.tree_handle;
		wr_entry.consumed  = (req_q.req_type == pmt_pkg::REQ_REC_SUCC) ?
			req_q.consumed_in : 32'd0;
		wr_entry.result    = (req_q.req_type == pmt_pkg::REQ_REC_SUCC) ?
			pmt_pkg::CODE_SUCC : pmt_pkg::CODE_FAIL;
	end

	// lookup compare and saturating advance
	assign hit = (req_q.req_type == pmt_pkg::REQ_LOOKUP) && rd_entry.valid &&
		(rd_entry.key == key) && (rd_entry.state_tag == req_q.state_tag);
	assign sum = {1'b0, req_q.position} + {1'b0, rd_entry.consumed};

	always_comb begin
		rsp_d.result_code  = pmt_pkg::CODE_NONE;
		rsp_d.new_position = req_q.position;
		rsp_d.tree_out     = req_q.tree_handle;
		if (hit) begin
			rsp_d.result_code  = rd_entry.result;
			rsp_d.new_position = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			rsp_d.tree_out     = rd_entry.tree;
		end else if (is_record) begin
			rsp_d.result_code  = wr_entry.result;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> sv/packrat_memo_table_top.sv
// ----------------------------------------------------------------------------
// packrat_memo_table_top: direct-mapped packrat memo table
// the result strobe is registered from the response state, which follows the
// 48-step key remainder loop and the slot read; a new request is accepted only
// in the idle state, so the block takes no item before the last one is through
// after reset busy stays high for a pass clearing the slots
// ----------------------------------------------------------------------------
`include "packrat_memo_table_top_defines.svh"

module packrat_memo_table_top #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pmt_pkg::pmt_req_t           req,
	input  logic                        cfg_we,
	input  logic [pmt_pkg::SLOTS_W-1:0] cfg_wdata,
	output logic                        done,
	output pmt_pkg::pmt_rsp_t           rsp
);

	pmt_pkg::pmt_cmd_t cmd;
	pmt_pkg::pmt_sts_t sts;

	// sequencer
	pmt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// datapath
	pmt_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp      (rsp)
	);

	// a transfer in makes the block busy, a result frees it
	`PMT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`PMT_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`PMT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`PMT_ASSERT_NEXT(a_no_early_done, clk, arst_n, start && !busy, !done)

endmodule
